// ----- design/rpn_pkg.sv -----
// Package for the RPN stack calculator: field widths, action, status and
// state codes, and the divider result bundle.
// No dependencies; imported by every module of the block.
`default_nettype none

package rpn_pkg;

  localparam int unsigned WORD_W          = 32;
  localparam int unsigned ACT_W           = 3;
  localparam int unsigned STAT_W          = 3;
  localparam int unsigned DEPTH_W         = 5;
  localparam int unsigned STACK_DEPTH_DEF = 16;

  typedef enum logic [ACT_W-1:0] {
    ACT_PUSH   = 3'd0,
    ACT_ADD    = 3'd1,
    ACT_SUB    = 3'd2,
    ACT_MULT   = 3'd3,
    ACT_DIV    = 3'd4,
    ACT_FINISH = 3'd5
  } action_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_UNDER   = 3'd2,
    ST_DIVZERO = 3'd3,
    ST_EMPTY   = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_READ = 2'd1,
    S_DIVW = 2'd2,
    S_PUT  = 2'd3
  } state_e;

  typedef struct packed {
    logic              done;
    logic [WORD_W-1:0] quotient;
  } div_res_t;

endpackage

`default_nettype wire

// ----- design/rpn_div.sv -----
// Radix-2 restoring divider on unsigned magnitudes, one quotient bit a cycle.
// Depends on rpn_pkg for the word width and the result bundle.
`default_nettype none

module rpn_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [rpn_pkg::WORD_W-1:0]  dividend_i,
  input  logic [rpn_pkg::WORD_W-1:0]  divisor_i,
  output rpn_pkg::div_res_t           res_o
);
  import rpn_pkg::*;

  localparam int unsigned CNT_W = $clog2(WORD_W);

  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [WORD_W-1:0] rem_q, rem_d;
  logic [WORD_W-1:0] quo_q, quo_d;
  logic [WORD_W-1:0] dvsr_q, dvsr_d;
  logic [WORD_W:0]   rem_sh;
  logic [WORD_W:0]   diff;
  logic              fits;

  assign rem_sh = {rem_q, quo_q[WORD_W-1]};
  assign diff   = rem_sh - {1'b0, dvsr_q};
  assign fits   = ~diff[WORD_W];

  always_comb begin
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvsr_d = dvsr_q;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      dvsr_d = divisor_i;
      busy_d = 1'b1;
      cnt_d  = '0;
    end else if (busy_q) begin
      rem_d = fits ? diff[WORD_W-1:0] : rem_sh[WORD_W-1:0];
      quo_d = {quo_q[WORD_W-2:0], fits};
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(WORD_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    dvsr_q <= dvsr_d;
  end

  assign res_o.done     = done_q;
  assign res_o.quotient = quo_q;

endmodule

`default_nettype wire

// ----- design/rpn_stack_calculator_top.sv -----
// Top level of the RPN stack calculator: stack memory, control FSM, ALU and
// output register. Depends on rpn_pkg and instantiates rpn_div.
//
//   channel  direction  handshake              payload
//   in       sink       in_valid_i/in_stall_o  action_i, operand_i
//   out      source     out_valid_o/out_stall_i status_o, top_value_o,
//                                              stack_depth_o, finished_o
//
// Push, finish, ignored and failed beats go IDLE, PUT; add, sub and mult
// go IDLE, READ, PUT; div goes IDLE, READ, DIVW (32-step radix-2 divider
// loop), PUT. One beat is in work at a time; the read of x is registered.
// Reset clears count, error and control; the stack memory needs no pass.
// A result held by out_stall_i stays in the output register while the
// next in beat is accepted; that beat's result waits for the register.
`default_nettype none

module rpn_stack_calculator_top #(
  parameter int unsigned STACK_DEPTH = rpn_pkg::STACK_DEPTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [rpn_pkg::ACT_W-1:0]           action_i,
  input  logic signed [rpn_pkg::WORD_W-1:0]   operand_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [rpn_pkg::STAT_W-1:0]          status_o,
  output logic signed [rpn_pkg::WORD_W-1:0]   top_value_o,
  output logic [rpn_pkg::DEPTH_W-1:0]         stack_depth_o,
  output logic                                finished_o
);
  import rpn_pkg::*;

  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

  logic [WORD_W-1:0] mem_q [STACK_DEPTH];
  logic [WORD_W-1:0] rd_q;
  logic              we;
  logic [AW-1:0]     wa;
  logic [AW-1:0]     ra;
  logic [WORD_W-1:0] wd;

  state_e            state_q, state_d;
  logic [CW-1:0]     count_q, count_d;
  status_e           err_q, err_d;
  logic [WORD_W-1:0] top_q, top_d;
  action_e           op_q, op_d;
  logic              neg_q, neg_d;
  logic              fin_q, fin_d;
  status_e           fin_st_q, fin_st_d;
  logic [WORD_W-1:0] fin_val_q, fin_val_d;

  logic               out_valid_q, out_valid_d;
  logic [STAT_W-1:0]  out_status_q, out_status_d;
  logic [WORD_W-1:0]  out_value_q, out_value_d;
  logic [DEPTH_W-1:0] out_depth_q, out_depth_d;
  logic               out_fin_q, out_fin_d;

  action_e           act;
  logic              in_acc;
  logic              is_op;
  logic              go_read;
  logic              slot_free;
  logic [WORD_W-1:0] alu_r;
  logic [WORD_W-1:0] prod;
  logic [WORD_W-1:0] quo_s;
  logic [WORD_W-1:0] x_mag;
  logic [WORD_W-1:0] y_mag;
  logic              div_start;
  div_res_t          div_res;
  logic [CW+DEPTH_W-1:0] cnt_ext;

  assign act       = action_e'(action_i);
  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc    = in_valid_i & ~in_stall_o;
  assign slot_free = ~out_valid_q | ~out_stall_i;
  assign ra        = AW'(count_q - CW'(2));
  assign cnt_ext   = {{DEPTH_W{1'b0}}, count_q};

  always_comb begin
    unique case (act) inside
      ACT_ADD, ACT_SUB, ACT_MULT, ACT_DIV: is_op = 1'b1;
      default:                             is_op = 1'b0;
    endcase
  end

  assign go_read = in_acc && (err_q == ST_OK) && (count_q >= CW'(2)) && is_op &&
                   !((act == ACT_DIV) && (top_q == '0));

  assign prod  = rd_q * top_q;
  assign x_mag = rd_q[WORD_W-1] ? (~rd_q + WORD_W'(1)) : rd_q;
  assign y_mag = top_q[WORD_W-1] ? (~top_q + WORD_W'(1)) : top_q;
  assign quo_s = neg_q ? (~div_res.quotient + WORD_W'(1)) : div_res.quotient;

  always_comb begin
    case (op_q)
      ACT_ADD:  alu_r = rd_q + top_q;
      ACT_SUB:  alu_r = rd_q - top_q;
      default:  alu_r = prod;
    endcase
  end

  rpn_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (x_mag),
    .divisor_i  (y_mag),
    .res_o      (div_res)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = go_read ? S_READ : S_PUT;
        end
      end
      S_READ: begin
        state_d = (op_q == ACT_DIV) ? S_DIVW : S_PUT;
      end
      S_DIVW: begin
        if (div_res.done) begin
          state_d = S_PUT;
        end
      end
      S_PUT: begin
        if (slot_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    count_d      = count_q;
    err_d        = err_q;
    top_d        = top_q;
    op_d         = op_q;
    neg_d        = neg_q;
    fin_d        = fin_q;
    fin_st_d     = fin_st_q;
    fin_val_d    = fin_val_q;
    we           = 1'b0;
    wa           = ra;
    wd           = alu_r;
    div_start    = 1'b0;
    out_valid_d  = out_valid_q & out_stall_i;
    out_status_d = out_status_q;
    out_value_d  = out_value_q;
    out_depth_d  = out_depth_q;
    out_fin_d    = out_fin_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          op_d  = act;
          fin_d = 1'b0;
          unique case (act) inside
            ACT_FINISH: begin
              fin_d = 1'b1;
              if (err_q != ST_OK) begin
                fin_st_d  = err_q;
                fin_val_d = '0;
              end else if (count_q == '0) begin
                fin_st_d  = ST_EMPTY;
                fin_val_d = '0;
              end else begin
                fin_st_d  = ST_OK;
                fin_val_d = top_q;
              end
              count_d = '0;
              err_d   = ST_OK;
            end
            ACT_PUSH: begin
              if (err_q == ST_OK) begin
                if (count_q >= CW'(STACK_DEPTH)) begin
                  err_d = ST_FULL;
                end else begin
                  we      = 1'b1;
                  wa      = AW'(count_q);
                  wd      = operand_i;
                  top_d   = operand_i;
                  count_d = count_q + CW'(1);
                end
              end
            end
            ACT_ADD, ACT_SUB, ACT_MULT, ACT_DIV: begin
              if (err_q == ST_OK) begin
                if (count_q < CW'(2)) begin
                  err_d = ST_UNDER;
                end else if ((act == ACT_DIV) && (top_q == '0)) begin
                  err_d = ST_DIVZERO;
                end
              end
            end
            default: ;
          endcase
        end
      end
      S_READ: begin
        if (op_q == ACT_DIV) begin
          div_start = 1'b1;
          neg_d     = rd_q[WORD_W-1] ^ top_q[WORD_W-1];
        end else begin
          we      = 1'b1;
          wd      = alu_r;
          top_d   = alu_r;
          count_d = count_q - CW'(1);
        end
      end
      S_DIVW: begin
        if (div_res.done) begin
          we      = 1'b1;
          wd      = quo_s;
          top_d   = quo_s;
          count_d = count_q - CW'(1);
        end
      end
      S_PUT: begin
        if (slot_free) begin
          out_valid_d  = 1'b1;
          out_status_d = fin_q ? fin_st_q : err_q;
          out_value_d  = fin_q ? fin_val_q : ((count_q == '0) ? '0 : top_q);
          out_depth_d  = cnt_ext[DEPTH_W-1:0];
          out_fin_d    = fin_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wa] <= wd;
    end
    rd_q <= mem_q[ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      err_q       <= ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q        <= top_d;
    op_q         <= op_d;
    neg_q        <= neg_d;
    fin_q        <= fin_d;
    fin_st_q     <= fin_st_d;
    fin_val_q    <= fin_val_d;
    out_status_q <= out_status_d;
    out_value_q  <= out_value_d;
    out_depth_q  <= out_depth_d;
    out_fin_q    <= out_fin_d;
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign top_value_o   = out_value_q;
  assign stack_depth_o = out_depth_q;
  assign finished_o    = out_fin_q;

endmodule

`default_nettype wire

// ----- design/rpn_chk.sv -----
// Port-level checker for the RPN stack calculator and its bind statement.
// Depends on rpn_pkg for status codes; binds to rpn_stack_calculator_top.
`default_nettype none

module rpn_chk (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_stall_o,
  input logic [rpn_pkg::ACT_W-1:0]          action_i,
  input logic signed [rpn_pkg::WORD_W-1:0]  operand_i,
  input logic                               out_valid_o,
  input logic                               out_stall_i,
  input logic [rpn_pkg::STAT_W-1:0]         status_o,
  input logic signed [rpn_pkg::WORD_W-1:0]  top_value_o,
  input logic [rpn_pkg::DEPTH_W-1:0]        stack_depth_o,
  input logic                               finished_o
);
  import rpn_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) &&
      $stable(top_value_o) && $stable(stack_depth_o) && $stable(finished_o))
    else $error("out beat changed while stalled");

  a_fin_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && finished_o |-> stack_depth_o == '0)
    else $error("finish beat left entries on the stack");

  a_empty_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_EMPTY) |-> finished_o && (top_value_o == '0))
    else $error("empty status outside a finish beat");

  a_zero_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !finished_o && (stack_depth_o == '0) |-> top_value_o == '0)
    else $error("nonzero top on an empty stack");

  a_one_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("in beat accepted before the previous one finished");

endmodule

bind rpn_stack_calculator_top rpn_chk u_rpn_chk (.*);

`default_nettype wire
